// ----- rtl/b64d_pkg.sv -----
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, codes and the alphabet lookup for the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  // decode phase codes
  localparam logic [1:0] PH_SKIP   = 2'd0;
  localparam logic [1:0] PH_DECODE = 2'd1;
  localparam logic [1:0] PH_ENDED  = 2'd2;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;

  localparam logic [6:0] SEXTET_PLUS    = 7'd62;
  localparam logic [6:0] SEXTET_SLASH   = 7'd63;
  localparam logic [6:0] NOT_IN_ALPHABET = 7'd64;

  // one decoded group: up to three bytes from one request, oldest in slot 0
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      count;   // results in the group, 1 to 3
    logic            marker;  // end marker only, no data byte
    logic            last;
    logic            limit;
  } grp_t;

  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] v;
    v = NOT_IN_ALPHABET;
    if (c >= 8'h41 && c <= 8'h5A) begin
      v = 7'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = 7'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = 7'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      v = SEXTET_PLUS;
    end else if (c == 8'h2F) begin
      v = SEXTET_SLASH;
    end
    return v;
  endfunction

endpackage

// ----- rtl/b64d_decode.sv -----
// ----------------------------------------------------------------------------
// b64d_decode
// Per-character decode step: string state, byte limit and the group register.
// ----------------------------------------------------------------------------
module b64d_decode import b64d_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char,
  input  logic        in_last,
  output logic        grp_valid,
  input  logic        grp_ready,
  output grp_t        grp
);

  logic [15:0] max_out_bytes;
  logic [17:0] store, store_next;
  logic [1:0]  cnt, cnt_next;
  logic [1:0]  phase, phase_next;
  logic [15:0] bytes_emitted, bytes_emitted_next;
  logic        overflow_seen, overflow_next;

  logic [2:0][7:0] cand;
  logic [1:0]      cand_n;
  logic [1:0]      acc_n;
  logic [16:0]     room;
  logic [6:0]      v;
  logic            accept;
  logic            push;

  assign accept   = in_valid && in_ready;
  assign in_ready = !grp_valid || grp_ready;
  assign v        = sextet_of(in_char);

  always_comb begin
    phase_next = phase;
    store_next = store;
    cnt_next   = cnt;
    cand       = '0;
    cand_n     = 2'd0;

    if (phase_next == PH_SKIP && in_char != CHAR_SPACE && in_char != CHAR_TAB) begin
      phase_next = PH_DECODE;
    end

    if (phase_next == PH_DECODE && v != NOT_IN_ALPHABET) begin
      if (cnt_next == 2'd3) begin
        cand[0]    = store_next[17:10];
        cand[1]    = store_next[9:2];
        cand[2]    = {store_next[1:0], v[5:0]};
        cand_n     = 2'd3;
        store_next = '0;
        cnt_next   = 2'd0;
      end else begin
        store_next = {store_next[11:0], v[5:0]};
        cnt_next   = cnt_next + 2'd1;
      end
    end

    // flush on a character outside the alphabet or at end of string
    if (phase_next == PH_DECODE && (v == NOT_IN_ALPHABET || in_last)) begin
      if (cnt_next == 2'd2) begin
        cand[0] = store_next[11:4];
        cand_n  = 2'd1;
      end else if (cnt_next == 2'd3) begin
        cand[0] = store_next[17:10];
        cand[1] = store_next[9:2];
        cand_n  = 2'd2;
      end
      store_next = '0;
      cnt_next   = 2'd0;
      phase_next = PH_ENDED;
    end

    // byte limit: only the leading bytes can pass
    room = (bytes_emitted < max_out_bytes) ?
           ({1'b0, max_out_bytes} - {1'b0, bytes_emitted}) : 17'd0;
    acc_n = (room >= {15'd0, cand_n}) ? cand_n : room[1:0];
    overflow_next      = overflow_seen || (acc_n != cand_n);
    bytes_emitted_next = bytes_emitted + {14'd0, acc_n};

    push = (acc_n != 2'd0) || in_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_out_bytes <= 16'hFFFF;
    end else if (cfg_valid) begin
      max_out_bytes <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      store         <= '0;
      cnt           <= 2'd0;
      phase         <= PH_SKIP;
      bytes_emitted <= '0;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      if (in_last) begin
        store         <= '0;
        cnt           <= 2'd0;
        phase         <= PH_SKIP;
        bytes_emitted <= '0;
        overflow_seen <= 1'b0;
      end else begin
        store         <= store_next;
        cnt           <= cnt_next;
        phase         <= phase_next;
        bytes_emitted <= bytes_emitted_next;
        overflow_seen <= overflow_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
    end else if (accept && push) begin
      grp_valid <= 1'b1;
    end else if (grp_ready) begin
      grp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && push) begin
      grp.bytes  <= cand;
      grp.count  <= (acc_n == 2'd0) ? 2'd1 : acc_n;
      grp.marker <= (acc_n == 2'd0);
      grp.last   <= in_last;
      grp.limit  <= overflow_next;
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    accept && in_last |=> phase == PH_SKIP && cnt == 2'd0 && bytes_emitted == 16'd0
      && !overflow_seen)
    else $error("string state not cleared after last request");

  a_marker_shape: assert property (@(posedge clk) disable iff (rst)
    grp_valid && grp.marker |-> grp.last && grp.count == 2'd1)
    else $error("end marker group malformed");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    grp_valid && !grp_ready |-> !in_ready)
    else $error("request taken while group register held");

endmodule

// ----- rtl/b64d_serial.sv -----
// ----------------------------------------------------------------------------
// b64d_serial
// Output register: hands out a group's results, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module b64d_serial import b64d_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       grp_valid,
  output logic       grp_ready,
  input  grp_t       grp,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       out_last,
  output logic       limit_hit
);

  logic [2:0][7:0] bytes;
  logic [1:0]      left;
  logic            marker;
  logic            last;
  logic            limit;
  logic            take;

  assign take      = out_valid && out_ready;
  assign grp_ready = !out_valid || (out_ready && left == 2'd1);

  assign out_byte   = marker ? 8'd0 : bytes[0];
  assign byte_valid = !marker;
  assign out_last   = last && left == 2'd1;
  assign limit_hit  = limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      left      <= 2'd0;
    end else if (grp_valid && grp_ready) begin
      out_valid <= 1'b1;
      left      <= grp.count;
    end else if (take) begin
      out_valid <= (left != 2'd1);
      left      <= left - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (grp_valid && grp_ready) begin
      bytes  <= grp.bytes;
      marker <= grp.marker;
      last   <= grp.last;
      limit  <= grp.limit;
    end else if (take) begin
      bytes <= {8'd0, bytes[2:1]};
    end
  end

  a_left_matches_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid == (left != 2'd0))
    else $error("result count out of step with valid");

  a_marker_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> out_last)
    else $error("end marker without last mark");

  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    take && out_last && !grp_valid |=> !out_valid)
    else $error("results left after last result");

endmodule

// ----- rtl/base64_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Decodes base64 text, one character per request, into a byte stream.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  -------  ---------  -------------------  ----------------------------------
//  cfg      in         cfg_valid/cfg_ready  cfg_data (max_out_bytes)
//  in       in         in_valid/in_ready    in_char, in_last
//  out      out        out_valid/out_ready  out_byte, byte_valid, out_last,
//                                           limit_hit
//
//  One character is taken per cycle while in_ready is high. A character that
//  passes bytes under the byte limit, or is marked last, loads a group of one
//  to three results in the cycle after; the output register then hands them
//  out one per cycle while out_ready is high. The group register and the
//  output register give two groups of slack, so a steady stream of four
//  characters per three bytes runs without stalls. Reset (rst, synchronous)
//  clears the string state and sets the byte limit to 65535. cfg_ready is
//  always high; write the limit only while idle. A stalled output holds the
//  current result, then the group register, then in_ready drops.
// ----------------------------------------------------------------------------
module base64_stream_decoder import b64d_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        out_last,
  output logic        limit_hit
);

  logic grp_valid;
  logic grp_ready;
  grp_t grp;

  // the limit register always takes a write
  assign cfg_ready = 1'b1;

  // decode step: string state, byte limit, group register
  b64d_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_char   (in_char),
    .in_last   (in_last),
    .grp_valid (grp_valid),
    .grp_ready (grp_ready),
    .grp       (grp)
  );

  // output register: advance one result per accepted output
  b64d_serial u_serial (
    .clk        (clk),
    .rst        (rst),
    .grp_valid  (grp_valid),
    .grp_ready  (grp_ready),
    .grp        (grp),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .out_last   (out_last),
    .limit_hit  (limit_hit)
  );

endmodule

// ----- tb/tb_base64_stream_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64_stream_decoder
// Self-checking bench for the base64 stream decoder. A queue of characters
// feeds a valid/ready driver. A behavioral decoder predicts the bytes and end
// markers of every accepted request. A monitor checks each delivered result,
// field by field, against the oldest prediction. Directed strings come first,
// then random strings under several byte limits, with random stalls on both
// sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_base64_stream_decoder;
  import b64d_pkg::*;

  localparam int          CLK_HALF_NS   = 2;
  localparam int          RESET_CYCLES  = 11;
  localparam int          SETTLE_CYCLES = 8;     // group stage plus output register
  localparam int          HOLD_CYCLES   = 300;   // long output hold-off
  localparam int          PHASE_CHARS   = 16;    // random characters per limit setting
  localparam int          RUN_LIMIT_NS  = 1_000_000;
  localparam logic [7:0]  PAD_CHAR      = 8'h3D;
  localparam logic [15:0] LIMIT_MAX     = 16'hFFFF;
  localparam logic [15:0] LIMIT_NONE    = 16'h0000;
  localparam logic [8*64-1:0] ALPHABET  =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } char_req_t;

  typedef struct {
    logic [7:0] data;
    logic       data_ok;
    logic       last;
    logic       limit;
  } dec_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_char = '0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        out_last;
  logic        limit_hit;

  // stimulus and scoreboard
  char_req_t   char_q[$];
  dec_result_t awaited_results[$];
  logic [7:0]  step_bytes[$];

  // behavioral decoder state
  logic [15:0] limit_cfg = LIMIT_MAX;
  logic [17:0] pend_bits = '0;
  logic [1:0]  pend_cnt = '0;
  logic [1:0]  phase = PH_SKIP;
  logic [15:0] emitted = '0;
  logic        dropped = 1'b0;

  // handshake pacing
  int   send_wait = 0;
  int   send_run = 0;
  int   recv_wait = 0;
  int   recv_run = 0;
  logic out_block = 1'b0;
  logic hold_go = 1'b0;

  int err_count = 0;
  int chars_queued = 0;
  int chars_taken = 0;
  int strings_sent = 0;
  int results_checked = 0;
  int limits_used = 0;

  base64_stream_decoder u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_char    (in_char),
    .in_last    (in_last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .out_last   (out_last),
    .limit_hit  (limit_hit)
  );

  initial begin : clock_gen
    forever begin
      #(CLK_HALF_NS) clk = ~clk;
    end
  end

  // --------------------------------------------------------------------------
  // Behavioral decoder
  // --------------------------------------------------------------------------

  function automatic logic [7:0] alpha_char(int idx);
    return ALPHABET[(63 - idx) * 8 +: 8];
  endfunction

  // map a character to its 6-bit value by searching the alphabet
  function automatic logic [6:0] char_value(logic [7:0] c);
    logic [6:0] v;
    v = NOT_IN_ALPHABET;
    for (int i = 0; i < 64; i++) begin
      if (alpha_char(i) == c) begin
        v = 7'(i);
      end
    end
    return v;
  endfunction

  // deliver one byte unless the per-string limit is used up
  function automatic void offer_byte(logic [7:0] b);
    if (emitted < limit_cfg) begin
      step_bytes.push_back(b);
      emitted = emitted + 16'd1;
    end else begin
      dropped = 1'b1;
    end
  endfunction

  // release a pending pair or triple and stop decoding this string
  function automatic void flush_pending();
    if (pend_cnt == 2'd2) begin
      offer_byte(pend_bits[11:4]);
    end else if (pend_cnt == 2'd3) begin
      offer_byte(pend_bits[17:10]);
      offer_byte(pend_bits[9:2]);
    end
    pend_bits = '0;
    pend_cnt  = '0;
    phase     = PH_ENDED;
  endfunction

  function automatic void clear_string();
    pend_bits = '0;
    pend_cnt  = '0;
    phase     = PH_SKIP;
    emitted   = '0;
    dropped   = 1'b0;
  endfunction

  // advance the decoder by one character and queue the results it causes
  function automatic void decode_char(logic [7:0] c, logic last);
    logic [6:0]  v;
    dec_result_t r;
    step_bytes.delete();
    if (phase == PH_SKIP && c != CHAR_SPACE && c != CHAR_TAB) begin
      phase = PH_DECODE;
    end
    if (phase == PH_DECODE) begin
      v = char_value(c);
      if (v == NOT_IN_ALPHABET) begin
        flush_pending();
      end else if (pend_cnt == 2'd3) begin
        offer_byte(pend_bits[17:10]);
        offer_byte(pend_bits[9:2]);
        offer_byte({pend_bits[1:0], v[5:0]});
        pend_bits = '0;
        pend_cnt  = '0;
      end else begin
        pend_bits = {pend_bits[11:0], v[5:0]};
        pend_cnt  = pend_cnt + 2'd1;
      end
    end
    if (last && phase == PH_DECODE) begin
      flush_pending();
    end
    if (last && step_bytes.size() == 0) begin
      r.data    = '0;
      r.data_ok = 1'b0;
      r.last    = 1'b1;
      r.limit   = dropped;
      awaited_results.push_back(r);
    end else begin
      foreach (step_bytes[k]) begin
        r.data    = step_bytes[k];
        r.data_ok = 1'b1;
        r.last    = last && (k == step_bytes.size() - 1);
        r.limit   = dropped;
        awaited_results.push_back(r);
      end
    end
    if (last) begin
      clear_string();
    end
  endfunction

  // --------------------------------------------------------------------------
  // Pacing: either side may idle before each request, with bursts of
  // back-to-back requests mixed in.
  // --------------------------------------------------------------------------
  function automatic int draw_wait(ref int run_left);
    int pick;
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      run_left = $urandom_range(8, 30);
      return 0;
    end else if (pick <= 4) begin
      return 0;
    end
    return $urandom_range(1, 16);
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: present the next queued character, hold it until taken,
  // predict its results at the accepting edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_chars
    char_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_valid && in_ready) begin
        decode_char(in_char, in_last);
        chars_taken++;
        send_wait = draw_wait(send_run);
      end
      if (in_valid && !in_ready) begin
        // hold the request until the decoder takes it
      end else if (send_wait > 0) begin
        send_wait--;
        in_valid <= 1'b0;
      end else if (char_q.size() != 0) begin
        nxt = char_q.pop_front();
        in_char  <= nxt.ch;
        in_last  <= nxt.last;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor: check every delivered result against the oldest
  // prediction, then draw the stall before the next one.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    err_count++;
    $display("%0t ns: %s: got %0h, want %0h", $time, what, got, want);
  endtask

  always @(posedge clk) begin : check_results
    dec_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_checked++;
        if (awaited_results.size() == 0) begin
          report_mismatch("result with nothing pending", out_byte, 8'h00);
        end else begin
          want = awaited_results.pop_front();
          if (out_byte !== want.data) begin
            report_mismatch("out_byte", out_byte, want.data);
          end
          if (byte_valid !== want.data_ok) begin
            report_mismatch("byte_valid", 8'(byte_valid), 8'(want.data_ok));
          end
          if (out_last !== want.last) begin
            report_mismatch("out_last", 8'(out_last), 8'(want.last));
          end
          if (limit_hit !== want.limit) begin
            report_mismatch("limit_hit", 8'(limit_hit), 8'(want.limit));
          end
        end
        recv_wait = draw_wait(recv_run);
      end
      if (out_block) begin
        out_ready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Long output hold-off: block ready while the sender keeps going, so the
  // decoder fills and drops in_ready. Toggle on the falling edge.
  initial begin : rx_holdoff
    wait (hold_go);
    @(negedge clk);
    out_block = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    out_block = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_char(logic [7:0] c, logic last);
    char_req_t req;
    req.ch   = c;
    req.last = last;
    char_q.push_back(req);
    chars_queued++;
    if (last) begin
      strings_sent++;
    end
  endtask

  task automatic queue_text(string s, logic last_on_end);
    for (int i = 0; i < s.len(); i++) begin
      queue_char(s[i], last_on_end && (i == s.len() - 1));
    end
  endtask

  // one random string: mostly well-formed text, some noise, some cut short
  task automatic queue_random_string();
    logic [7:0] text[$];
    int         kind;
    kind = $urandom_range(0, 9);
    repeat ($urandom_range(0, 3)) begin
      text.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
    end
    if (kind <= 6) begin
      repeat ($urandom_range(0, 12)) text.push_back(alpha_char($urandom_range(0, 63)));
      if ($urandom_range(0, 1) == 1) begin
        repeat ($urandom_range(1, 2)) text.push_back(PAD_CHAR);
      end
      repeat ($urandom_range(0, 2)) text.push_back(8'($urandom_range(0, 255)));
    end else if (kind <= 8) begin
      repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 5)) text.push_back(alpha_char($urandom_range(0, 63)));
    end
    if (text.size() == 0) begin
      text.push_back(PAD_CHAR);
    end
    foreach (text[i]) begin
      queue_char(text[i], i == text.size() - 1);
    end
  endtask

  // wait until every character is taken and every result delivered, then
  // give the pipeline time to drain requests that produce nothing
  task automatic wait_idle();
    do @(posedge clk);
    while (chars_taken != chars_queued || awaited_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(logic [15:0] v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    limit_cfg = v;
    limits_used++;
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int phase_start;
    logic [15:0] random_limits[5];

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed: whitespace skip, pad ends a triple, pad ends a pair,
    // 62 and 63 completing a quartet on last, lone value dropped,
    // non-alphabet first, whitespace only, NUL ending a pair
    write_limit(LIMIT_MAX);
    queue_text(" \tTWE=", 1'b1);
    queue_text("QQ=", 1'b1);
    queue_text("+/9z", 1'b1);
    queue_text("A", 1'b1);
    queue_char(8'hFF, 1'b1);
    queue_text(" ", 1'b1);
    queue_text("AB", 1'b0);
    queue_char(8'h00, 1'b0);
    queue_text("x", 1'b1);
    wait_idle();

    // zero limit: every byte dropped, only a flagged end marker
    write_limit(LIMIT_NONE);
    queue_text("TWFu", 1'b1);
    wait_idle();

    // raise the limit in the middle of a string that already overflowed
    write_limit(16'd2);
    queue_text("TWFu", 1'b0);
    wait_idle();
    write_limit(LIMIT_MAX);
    queue_text("TQ", 1'b1);
    wait_idle();

    // random strings under several limits; hold the output off in the last
    random_limits[0] = 16'd3;
    random_limits[1] = LIMIT_NONE;
    random_limits[2] = 16'($urandom_range(7, 65534));
    random_limits[3] = 16'd1;
    random_limits[4] = LIMIT_MAX;
    foreach (random_limits[p]) begin
      write_limit(random_limits[p]);
      phase_start = chars_queued;
      while (chars_queued - phase_start < PHASE_CHARS) begin
        queue_random_string();
      end
      if (p == 4) begin
        while (chars_queued - phase_start < 2 * PHASE_CHARS) begin
          queue_random_string();
        end
        hold_go = 1'b1;
      end
      wait_idle();
    end

    $display("Decoded %0d strings from %0d characters; %0d results checked",
             strings_sent, chars_taken, results_checked);
    $display("Byte limit written %0d times, zero and full range included; %0d cycles held off",
             limits_used, HOLD_CYCLES);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("Timeout: %0d results still pending", awaited_results.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
